// ===== src/tsmfr_pkg.sv =====
// ----------------------------------------------------------------------------
// tsmfr_pkg
// Shared types and constants of the transport-stream frame reassembler.
// ----------------------------------------------------------------------------
package tsmfr_pkg;

    localparam int FRAME_BUF_BYTES_DEF = 2048;
    localparam int PKT_LEN             = 188;
    localparam int PLAIN_PAYLOAD       = 184;
    localparam int WORD_BYTES          = 4;
    localparam int MAX_WORDS           = 45;
    localparam int MIN_LEN_RESET       = 22;
    localparam int RES_FIFO_DEPTH      = 4;

    // Header byte positions inside a packet.
    localparam logic [7:0] POS_SYNC      = 8'd0;
    localparam logic [7:0] POS_FLAGS     = 8'd1;
    localparam logic [7:0] POS_CTRL      = 8'd3;
    localparam logic [7:0] POS_LEN       = 8'd6;
    localparam logic [7:0] POS_PAD       = 8'd7;
    localparam logic [7:0] POS_PLAIN_PLD = 8'd4;
    localparam logic [7:0] POS_ADAPT_PLD = 8'd8;

    localparam logic [1:0] ADAPT_BIT  = 2'b10;
    localparam logic [7:0] START_MASK = 8'h40;

    // Result kinds.
    localparam logic [2:0] KIND_PAYLOAD    = 3'd0;
    localparam logic [2:0] KIND_COMPLETE   = 3'd1;
    localparam logic [2:0] KIND_TOO_SHORT  = 3'd2;
    localparam logic [2:0] KIND_NO_START   = 3'd3;
    localparam logic [2:0] KIND_OVERFLOW   = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [10:0] offset;
        logic [7:0]  data;
        logic [12:0] length;
        logic        last;
    } res_t;

endpackage

// ===== src/ts_to_mac_frame_reassembler.sv =====
// ----------------------------------------------------------------------------
// ts_to_mac_frame_reassembler
// Rebuilds frames from 188-byte transport packets taken one byte a beat.
// ----------------------------------------------------------------------------
// Output: results are registered in the queue and offered in order from its head.
// Throughput: one byte beat per cycle; a frame's last payload byte gives two
// result beats, and input ready drops while the result queue has fewer than
// two free slots.
// Reset: rst_n clears all packet and frame state and the result queue, and
// sets min_frame_length to 22.
// ----------------------------------------------------------------------------
module ts_to_mac_frame_reassembler #(
    parameter int FRAME_BUF_BYTES = tsmfr_pkg::FRAME_BUF_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    // Byte input channel.
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        ts_byte,
    input  logic              packet_start,
    // Result channel.
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        kind,
    output logic [10:0]       frame_offset,
    output logic [7:0]        data_byte,
    output logic signed [12:0] frame_length,
    output logic              is_last,
    // Configuration write channel for min_frame_length.
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data
);
    import tsmfr_pkg::*;

    logic [7:0] min_len_reg;
    logic       step;
    logic       room2;
    res_t       res0, res1, head;
    logic [1:0] res_count;

    // Always takes a write; write it only while idle, which is not enforced.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= 8'(MIN_LEN_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            min_len_reg <= cfg_data;
        end
    end

    // A byte beat is taken whenever the queue can hold the two results that
    // it might cause.
    assign in_ready = room2;
    assign step     = in_valid && in_ready;

    tsmfr_core #(
        .FRAME_BUF_BYTES (FRAME_BUF_BYTES)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (step),
        .ts_byte          (ts_byte),
        .packet_start     (packet_start),
        .min_frame_length (min_len_reg),
        .res0             (res0),
        .res1             (res1),
        .res_count        (res_count)
    );

    // Results are registered in the queue; the head entry drives the ports.
    tsmfr_res_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (step),
        .wr_count (res_count),
        .wr0      (res0),
        .wr1      (res1),
        .room2    (room2),
        .rd_valid (out_valid),
        .rd_ready (out_ready),
        .rd_data  (head)
    );

    assign kind         = head.kind;
    assign frame_offset = head.offset;
    assign data_byte    = head.data;
    assign frame_length = $signed(head.length);
    assign is_last      = head.last;

endmodule

// ===== src/tsmfr_core.sv =====
// ----------------------------------------------------------------------------
// tsmfr_core
// Packet state and per-byte decision logic; produces up to two results a beat.
// ----------------------------------------------------------------------------
module tsmfr_core #(
    parameter int FRAME_BUF_BYTES = tsmfr_pkg::FRAME_BUF_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        ts_byte,
    input  logic              packet_start,
    input  logic [7:0]        min_frame_length,
    output tsmfr_pkg::res_t   res0,
    output tsmfr_pkg::res_t   res1,
    output logic [1:0]        res_count
);
    import tsmfr_pkg::*;

    localparam int FS_W = $clog2(FRAME_BUF_BYTES + 1);
    localparam int LW   = (FS_W + 1 > 13) ? FS_W + 1 : 13;
    localparam int OW   = (FS_W > 11) ? FS_W : 11;
    localparam logic [FS_W:0] BUF_LIM = (FS_W + 1)'(FRAME_BUF_BYTES);

    logic [7:0]      byte_position_reg, byte_position_next;
    logic [FS_W-1:0] frame_size_reg, frame_size_next;
    logic            start_flag_reg, start_flag_next;
    logic            adapt_present_reg, adapt_present_next;
    logic [7:0]      payload_bytes_reg, payload_bytes_next;
    logic [7:0]      pad_count_reg, pad_count_next;
    logic            packet_accepted_reg, packet_accepted_next;

    logic [7:0]      pos;
    logic [7:0]      words;
    logic            adapt_in;
    logic [FS_W-1:0] fs_eff;
    logic [FS_W-1:0] fs_inc;
    logic [FS_W-1:0] fs_done;
    logic [7:0]      pad_done;
    logic [OW-1:0]   fs_ext;
    logic signed [LW-1:0] diff;
    logic            do_complete;
    res_t            r0, r1, rc;
    logic [1:0]      n;

    always_comb
    begin
        pos      = packet_start ? POS_SYNC : byte_position_reg;
        adapt_in = (ts_byte[5:4] & ADAPT_BIT) != 2'b00;
        words    = (ts_byte > 8'(MAX_WORDS)) ? 8'(MAX_WORDS) : ts_byte;
        fs_eff   = start_flag_reg ? '0 : frame_size_reg;
        fs_inc   = frame_size_reg + 1'b1;
        fs_ext   = OW'(frame_size_reg);

        byte_position_next   = (pos == 8'(PKT_LEN)) ? 8'(PKT_LEN) : pos + 8'd1;
        frame_size_next      = frame_size_reg;
        start_flag_next      = start_flag_reg;
        adapt_present_next   = adapt_present_reg;
        payload_bytes_next   = payload_bytes_reg;
        pad_count_next       = pad_count_reg;
        packet_accepted_next = packet_accepted_reg;

        r0          = '0;
        r1          = '0;
        n           = 2'd0;
        do_complete = 1'b0;
        fs_done     = frame_size_reg;
        pad_done    = pad_count_reg;

        if (pos == POS_SYNC)
        begin
            packet_accepted_next = 1'b0;
            payload_bytes_next   = '0;
            pad_count_next       = '0;
        end
        else if (pos == POS_FLAGS)
        begin
            start_flag_next = (ts_byte & START_MASK) != 8'd0;
        end
        else if (pos == POS_CTRL)
        begin
            adapt_present_next = adapt_in;
            pad_count_next     = '0;
            payload_bytes_next = '0;
            frame_size_next    = fs_eff;
            if (!start_flag_reg && frame_size_reg == '0)
            begin
                packet_accepted_next = 1'b0;
                r0.kind              = KIND_NO_START;
                n                    = 2'd1;
            end
            else if (!adapt_in)
            begin
                if (({1'b0, fs_eff} + (FS_W + 1)'(PLAIN_PAYLOAD)) > BUF_LIM)
                begin
                    packet_accepted_next = 1'b0;
                    r0.kind              = KIND_OVERFLOW;
                    n                    = 2'd1;
                end
                else
                begin
                    packet_accepted_next = 1'b1;
                    payload_bytes_next   = 8'(PLAIN_PAYLOAD);
                end
            end
            else
            begin
                packet_accepted_next = 1'b1;
            end
        end
        else if (packet_accepted_reg && adapt_present_reg && pos == POS_LEN)
        begin
            payload_bytes_next = 8'(words * 8'(WORD_BYTES));
        end
        else if (packet_accepted_reg && adapt_present_reg && pos == POS_PAD)
        begin
            pad_count_next = ts_byte;
            pad_done       = ts_byte;
            if (({1'b0, frame_size_reg} + (FS_W + 1)'(payload_bytes_reg)) > BUF_LIM)
            begin
                packet_accepted_next = 1'b0;
                r0.kind              = KIND_OVERFLOW;
                n                    = 2'd1;
            end
            else if (payload_bytes_reg == 8'd0)
            begin
                do_complete = 1'b1;
                n           = 2'd1;
            end
        end
        else if (packet_accepted_reg && pos < 8'(PKT_LEN) && payload_bytes_reg != 8'd0
                 && pos >= (adapt_present_reg ? POS_ADAPT_PLD : POS_PLAIN_PLD))
        begin
            r0.kind            = KIND_PAYLOAD;
            r0.offset          = fs_ext[10:0];
            r0.data            = ts_byte;
            n                  = 2'd1;
            frame_size_next    = fs_inc;
            fs_done            = fs_inc;
            payload_bytes_next = payload_bytes_reg - 8'd1;
            if (payload_bytes_reg == 8'd1)
            begin
                if (adapt_present_reg)
                begin
                    do_complete = 1'b1;
                    n           = 2'd2;
                end
                else
                begin
                    packet_accepted_next = 1'b0;
                end
            end
        end

        // Frame completion: length after pad removal against the minimum.
        diff = $signed(LW'(fs_done)) - $signed(LW'(pad_done));
        rc        = '0;
        rc.kind   = (diff > $signed(LW'(min_frame_length))) ? KIND_COMPLETE
                                                            : KIND_TOO_SHORT;
        rc.length = diff[12:0];
        if (do_complete)
        begin
            frame_size_next      = '0;
            packet_accepted_next = 1'b0;
            if (n == 2'd2)
                r1 = rc;
            else
                r0 = rc;
        end

        if (n == 2'd1)
            r0.last = 1'b1;
        if (n == 2'd2)
            r1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg   <= '0;
            frame_size_reg      <= '0;
            start_flag_reg      <= 1'b0;
            adapt_present_reg   <= 1'b0;
            payload_bytes_reg   <= '0;
            pad_count_reg       <= '0;
            packet_accepted_reg <= 1'b0;
        end
        else if (step)
        begin
            byte_position_reg   <= byte_position_next;
            frame_size_reg      <= frame_size_next;
            start_flag_reg      <= start_flag_next;
            adapt_present_reg   <= adapt_present_next;
            payload_bytes_reg   <= payload_bytes_next;
            pad_count_reg       <= pad_count_next;
            packet_accepted_reg <= packet_accepted_next;
        end
    end

    assign res0      = r0;
    assign res1      = r1;
    assign res_count = n;

endmodule

// ===== src/tsmfr_res_fifo.sv =====
// ----------------------------------------------------------------------------
// tsmfr_res_fifo
// Small result queue: takes up to two results a cycle, hands out one a beat.
// ----------------------------------------------------------------------------
module tsmfr_res_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  logic [1:0]      wr_count,
    input  tsmfr_pkg::res_t wr0,
    input  tsmfr_pkg::res_t wr1,
    output logic            room2,
    output logic            rd_valid,
    input  logic            rd_ready,
    output tsmfr_pkg::res_t rd_data
);
    import tsmfr_pkg::*;

    localparam int PW = $clog2(RES_FIFO_DEPTH);
    localparam int CW = $clog2(RES_FIFO_DEPTH + 1);

    res_t          mem_reg [RES_FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    n_wr;
    logic          do_rd;
    logic [PW-1:0] wr_ptr_p1;

    always_comb
    begin
        n_wr        = wr_en ? wr_count : 2'd0;
        do_rd       = rd_valid && rd_ready;
        wr_ptr_p1   = wr_ptr_reg + 1'b1;
        wr_ptr_next = wr_ptr_reg + PW'(n_wr);
        rd_ptr_next = rd_ptr_reg + PW'(do_rd);
        count_next  = count_reg + CW'(n_wr) - CW'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_wr != 2'd0)
            mem_reg[wr_ptr_reg] <= wr0;
        if (n_wr == 2'd2)
            mem_reg[wr_ptr_p1] <= wr1;
    end

    assign room2    = count_reg <= CW'(RES_FIFO_DEPTH - 2);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem_reg[rd_ptr_reg];

endmodule

// ===== bench/frame_reassembly_checker.sv =====
// ----------------------------------------------------------------------------
// frame_reassembly_checker
// Watches the byte, result and configuration channels of the reassembler,
// predicts the result beats of every accepted byte and compares them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module frame_reassembly_checker #(
    parameter int BUF_BYTES = tsmfr_pkg::FRAME_BUF_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [7:0]         ts_byte,
    input  logic               packet_start,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [2:0]         kind,
    input  logic [10:0]        frame_offset,
    input  logic [7:0]         data_byte,
    input  logic signed [12:0] frame_length,
    input  logic               is_last,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [7:0]         cfg_data,
    output int                 results_pending,
    output int                 failures
);

    import tsmfr_pkg::*;

    // Predicted copy of the reassembly state.
    logic [7:0]  next_pos;
    logic [11:0] frame_bytes;
    logic        frame_start_seen;
    logic        has_adapt;
    logic [7:0]  bytes_left;
    logic [7:0]  pad_bytes;
    logic        pkt_taken;
    logic [7:0]  min_len;

    res_t expected_results[$];

    function automatic res_t make_result(input logic [2:0] k, input logic [10:0] off,
                                         input logic [7:0] d, input logic [12:0] len);
        res_t r;
        r.kind   = k;
        r.offset = off;
        r.data   = d;
        r.length = len;
        r.last   = 1'b0;
        return r;
    endfunction

    // Closes the frame: the length is taken after pad removal and compared
    // as a signed number against the configured minimum.
    task automatic close_frame(output res_t r);
        logic [12:0] len13;
        int          slen;
        len13 = {1'b0, frame_bytes} - {5'd0, pad_bytes};
        slen  = int'(frame_bytes) - int'(pad_bytes);
        r = make_result((slen > int'(min_len)) ? KIND_COMPLETE : KIND_TOO_SHORT,
                        11'd0, 8'd0, len13);
        frame_bytes = '0;
        pkt_taken   = 1'b0;
    endtask

    task automatic predict_beat(input logic [7:0] b, input logic st);
        logic [7:0] pos;
        res_t       r[2];
        int         n;
        int         words;
        n   = 0;
        pos = st ? POS_SYNC : next_pos;
        if (pos == POS_SYNC) begin
            pkt_taken  = 1'b0;
            bytes_left = '0;
            pad_bytes  = '0;
        end
        else if (pos == POS_FLAGS) begin
            frame_start_seen = (b & START_MASK) != 0;
        end
        else if (pos == POS_CTRL) begin
            has_adapt  = (b[5:4] & ADAPT_BIT) != 0;
            pad_bytes  = '0;
            bytes_left = '0;
            if (frame_start_seen)
                frame_bytes = '0;
            if (!frame_start_seen && frame_bytes == 0) begin
                pkt_taken = 1'b0;
                r[n] = make_result(KIND_NO_START, 11'd0, 8'd0, 13'd0);
                n++;
            end
            else if (!has_adapt) begin
                if (int'(frame_bytes) + PLAIN_PAYLOAD > BUF_BYTES) begin
                    pkt_taken = 1'b0;
                    r[n] = make_result(KIND_OVERFLOW, 11'd0, 8'd0, 13'd0);
                    n++;
                end
                else begin
                    pkt_taken  = 1'b1;
                    bytes_left = 8'(PLAIN_PAYLOAD);
                end
            end
            else begin
                pkt_taken = 1'b1;
            end
        end
        else if (pkt_taken && has_adapt && pos == POS_LEN) begin
            words      = (b > MAX_WORDS) ? MAX_WORDS : int'(b);
            words      = words * WORD_BYTES;
            bytes_left = words[7:0];
        end
        else if (pkt_taken && has_adapt && pos == POS_PAD) begin
            pad_bytes = b;
            if (int'(frame_bytes) + int'(bytes_left) > BUF_BYTES) begin
                pkt_taken = 1'b0;
                r[n] = make_result(KIND_OVERFLOW, 11'd0, 8'd0, 13'd0);
                n++;
            end
            else if (bytes_left == 0) begin
                close_frame(r[n]);
                n++;
            end
        end
        else if (pkt_taken && pos < PKT_LEN && bytes_left > 0 &&
                 pos >= (has_adapt ? POS_ADAPT_PLD : POS_PLAIN_PLD)) begin
            r[n] = make_result(KIND_PAYLOAD, frame_bytes[10:0], b, 13'd0);
            n++;
            frame_bytes = frame_bytes + 1'b1;
            bytes_left  = bytes_left - 1'b1;
            if (bytes_left == 0) begin
                if (has_adapt) begin
                    close_frame(r[n]);
                    n++;
                end
                else begin
                    pkt_taken = 1'b0;
                end
            end
        end
        next_pos = (int'(pos) + 1 > PKT_LEN) ? 8'(PKT_LEN) : pos + 1'b1;
        if (n > 0)
            r[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_results.push_back(r[i]);
    endtask

    task automatic check_result();
        res_t exp_r;
        if (expected_results.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("check: unexpected result kind=%0d offset=%0d data=%0d ",
                         kind, frame_offset, data_byte,
                         "length=%0d last=%0d", frame_length, is_last);
        end
        else begin
            exp_r = expected_results.pop_front();
            if (kind !== exp_r.kind || frame_offset !== exp_r.offset ||
                data_byte !== exp_r.data || frame_length !== exp_r.length ||
                is_last !== exp_r.last) begin
                failures++;
                if (failures <= 10)
                    $display("check: mismatch expected kind=%0d offset=%0d data=%0d ",
                             exp_r.kind, exp_r.offset, exp_r.data,
                             "length=%0d last=%0d, ", $signed(exp_r.length), exp_r.last,
                             "got kind=%0d offset=%0d data=%0d ",
                             kind, frame_offset, data_byte,
                             "length=%0d last=%0d", frame_length, is_last);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            next_pos         = '0;
            frame_bytes      = '0;
            frame_start_seen = 1'b0;
            has_adapt        = 1'b0;
            bytes_left       = '0;
            pad_bytes        = '0;
            pkt_taken        = 1'b0;
            min_len          = 8'(MIN_LEN_RESET);
            failures         = 0;
            expected_results.delete();
            results_pending <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready)
                min_len = cfg_data;
            if (in_valid && in_ready)
                predict_beat(ts_byte, packet_start);
            if (out_valid && out_ready)
                check_result();
            results_pending <= expected_results.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives transport packets into the frame reassembler one byte beat at a time,
// with random gaps and output stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    import tsmfr_pkg::*;

    // About a third of the random byte beats go into each random phase.
    localparam int RANDOM_BYTES_PER_PHASE = 470;
    // Each result is registered in the queue after its byte; the settle time also
    // covers a byte that is still in flight but causes no result.
    localparam int SETTLE_CYCLES  = 4;
    // Cycles without any beat on any channel before the run is given up.
    localparam int WATCHDOG_LIMIT = 2000;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_ready;
    logic [7:0]        ts_byte      = 8'd0;
    logic              packet_start = 1'b0;
    logic              out_valid;
    logic              out_ready    = 1'b0;
    logic [2:0]        kind;
    logic [10:0]       frame_offset;
    logic [7:0]        data_byte;
    logic signed [12:0] frame_length;
    logic              is_last;
    logic              cfg_valid    = 1'b0;
    logic              cfg_ready;
    logic [7:0]        cfg_data     = 8'd0;

    int results_pending;
    int check_failures;
    int tx_gap_pct   = 17;
    int rx_stall_pct = 84;
    int bytes_sent   = 0;
    int quiet_cycles = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ts_to_mac_frame_reassembler i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .ts_byte      (ts_byte),
        .packet_start (packet_start),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .frame_offset (frame_offset),
        .data_byte    (data_byte),
        .frame_length (frame_length),
        .is_last      (is_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    frame_reassembly_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .ts_byte         (ts_byte),
        .packet_start    (packet_start),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .frame_offset    (frame_offset),
        .data_byte       (data_byte),
        .frame_length    (frame_length),
        .is_last         (is_last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .results_pending (results_pending),
        .failures        (check_failures)
    );

    // The receiver decides afresh at every falling edge whether to stall.
    // With a stall rate of zero it takes every result beat.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= rx_stall_pct);

    // Any accepted beat on any channel proves the design is still moving.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // Offers one byte beat. The task is entered right after an accepting edge
    // (or while idle), so valid changes only at the next falling edge, and it
    // returns at the rising edge that accepts the beat with valid still high.
    task automatic push_byte(input logic [7:0] b, input logic st);
        @(negedge clk);
        while ($urandom_range(99) < tx_gap_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        ts_byte      <= b;
        packet_start <= st;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Sends n bytes of one packet. The start flag sits in bit 6 of header
    // byte 1 and the adaptation bit in bit 5 of header byte 3; with adaptation
    // the word count and pad count go to bytes 6 and 7. Everything else is
    // random. Bytes beyond the packet length go out without packet_start, and
    // mark_first low leaves packet_start off even on the first byte.
    task automatic send_packet(input logic mark_first, input logic frame_start,
                               input logic adapt, input logic [7:0] words,
                               input logic [7:0] pad, input int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom);
            if (i == POS_FLAGS)
                b = (b & ~START_MASK) | (frame_start ? START_MASK : 8'h00);
            else if (i == POS_CTRL)
                b[5] = adapt;
            else if (adapt && i == POS_LEN)
                b = words;
            else if (adapt && i == POS_PAD)
                b = pad;
            push_byte(b, (i == 0) ? mark_first : 1'b0);
        end
    endtask

    // Mostly well-formed packets with random content. Adaptation packets
    // usually stop right after their payload so that the next packet cuts
    // them short, which keeps frames quick and the result rate high. A few
    // packets run the full length or beyond, a few stop inside the header,
    // and some bursts are plain noise with random packet_start marks.
    task automatic send_random_packet();
        int         sel;
        int         n;
        logic       st;
        logic       ad;
        logic [7:0] w;
        logic [7:0] p;
        sel = $urandom_range(99);
        if (sel < 6) begin
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++)
                push_byte(8'($urandom), $urandom_range(9) == 0);
        end
        else begin
            st  = ($urandom_range(99) < 70);
            ad  = ($urandom_range(99) < 60);
            sel = $urandom_range(99);
            if (sel < 80)
                w = 8'($urandom_range(0, 12));
            else if (sel < 90)
                w = 8'($urandom_range(13, MAX_WORDS));
            else
                w = 8'($urandom_range(MAX_WORDS + 1, 255));
            p = ($urandom_range(99) < 70) ? 8'($urandom_range(0, 15))
                                          : 8'($urandom_range(0, 255));
            if (ad) begin
                if ($urandom_range(99) < 12)
                    n = PKT_LEN;
                else if ($urandom_range(99) < 8)
                    n = $urandom_range(1, 8);
                else
                    n = 8 + WORD_BYTES * ((w > MAX_WORDS) ? MAX_WORDS : int'(w)) +
                        $urandom_range(0, 2);
            end
            else begin
                n = ($urandom_range(99) < 15) ? PKT_LEN : $urandom_range(4, 40);
            end
            if (n == PKT_LEN && $urandom_range(99) < 20)
                n += $urandom_range(1, 4);
            send_packet(1'b1, st, ad, w, p, n);
        end
    endtask

    // Lowers valid, waits until every predicted result beat has come back,
    // then lets the pipeline settle. The first edge makes sure the checker
    // has counted the last byte before its pending count is trusted.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_min_len(input logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase();
        int first;
        first = bytes_sent;
        while (bytes_sent - first < RANDOM_BYTES_PER_PHASE)
            send_random_packet();
    endtask

    initial begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, run with the reset minimum of 22. The very first
        // byte has no packet_start and must still count as byte 0; that
        // packet has no start flag on an empty frame and is dropped.
        send_packet(1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 4);
        // A plain start packet cut short after three payload bytes, then a
        // continuation with one payload word that ends a seven-byte frame.
        send_packet(1'b1, 1'b1, 1'b0, 8'd0, 8'd0, 7);
        send_packet(1'b1, 1'b0, 1'b1, 8'd1, 8'd0, 12);
        // An empty final payload with the largest pad: completion at byte 7
        // with the most negative length.
        send_packet(1'b1, 1'b1, 1'b1, 8'd0, 8'd255, 8);
        drain();

        // Random phases: slow receiver, then slow sender, then full speed.
        write_min_len(8'd0);
        random_phase();
        drain();

        tx_gap_pct   = 84;
        rx_stall_pct = 17;
        write_min_len(8'($urandom_range(1, 254)));
        random_phase();
        drain();

        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        write_min_len(8'($urandom_range(0, 255)));
        random_phase();
        drain();

        if (check_failures == 0 && results_pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
